// ===== src/wps_pkg.sv =====
// shared constants and types of the led pixel serialiser
package wps_pkg;

    localparam int unsigned LANES_DEFAULT = 16;
    localparam int unsigned BPP_DEFAULT   = 24;
    localparam int unsigned COLOUR_BITS   = 24;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_LANE_MASK        = 3'd0;
    localparam cfg_index_t REG_PIXEL_COUNT      = 3'd1;
    localparam cfg_index_t REG_BIT_PERIOD       = 3'd2;
    localparam cfg_index_t REG_ZERO_HIGH        = 3'd3;
    localparam cfg_index_t REG_ONE_HIGH         = 3'd4;
    localparam cfg_index_t REG_FRAME_SLOTS      = 3'd5;
    localparam cfg_index_t REG_BRIGHTNESS_SHIFT = 3'd6;

    localparam logic [15:0] LANE_MASK_RESET    = 16'd1;
    localparam logic [10:0] PIXEL_COUNT_RESET  = 11'd0;
    localparam logic [6:0]  BIT_PERIOD_RESET   = 7'd45;
    localparam logic [6:0]  ZERO_HIGH_RESET    = 7'd14;
    localparam logic [6:0]  ONE_HIGH_RESET     = 7'd29;
    localparam logic [15:0] FRAME_SLOTS_RESET  = 16'd40000;
    localparam logic [2:0]  BRIGHTNESS_RESET   = 3'd0;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic        underrun;
        logic        in_latch;
        logic        wants_pixel;
        logic        pixel_accepted;
        logic [15:0] pin_levels;
    } result_t;

endpackage

// ===== src/ws2812_pixel_serializer_unit.sv =====
// led chain serialiser: pixel hold register, bit timer and frame counter
// One transaction per clock in both directions: an item is held in the input register,
// the counter and hold-register update is done in a single pass as it moves to the
// result register, and a new item is taken every cycle while the result side keeps up.
// A tick item advances the bit timer by one; a pixel item only fills the hold register.
// Configuration writes are taken at any time, always ready, and should be made while no
// item is in flight.
module ws2812_pixel_serializer_unit #(
    parameter int unsigned LANES          = wps_pkg::LANES_DEFAULT,
    parameter int unsigned BITS_PER_PIXEL = wps_pkg::BPP_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,  // red, green, blue
    input  logic [0:0]                       s_tuser,  // op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pin_levels, pixel_accepted, wants_pixel, in_latch, underrun, zero fill
    output logic [23:0]                      m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wps_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wps_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int unsigned BitW     = $clog2(BITS_PER_PIXEL);
    localparam int unsigned LaneBits = (LANES < 16) ? LANES : 16;
    localparam logic [15:0] LanePins = 16'((32'd1 << LaneBits) - 32'd1);

    // configuration
    logic [15:0] lane_mask_reg;
    logic [10:0] pixel_count_reg;
    logic [6:0]  bit_period_reg;
    logic [6:0]  zero_high_reg;
    logic [6:0]  one_high_reg;
    logic [15:0] frame_slots_reg;
    logic [2:0]  brightness_reg;
    logic [15:0] active_reg;

    // input stage
    logic        item_valid_reg;
    logic        item_op_reg;
    logic [7:0]  item_red_reg;
    logic [7:0]  item_green_reg;
    logic [7:0]  item_blue_reg;

    // serialiser state
    logic [23:0]     hold_pixel_reg, hold_pixel_next;
    logic            hold_valid_reg, hold_valid_next;
    logic [23:0]     shift_pixel_reg, shift_pixel_next;
    logic [BitW-1:0] bit_index_reg, bit_index_next;
    logic [6:0]      tick_in_slot_reg, tick_in_slot_next;
    logic [15:0]     slot_in_frame_reg, slot_in_frame_next;
    logic [10:0]     pixel_index_reg, pixel_index_next;
    logic [15:0]     last_level_reg, last_level_next;

    // result stage
    logic              out_valid_reg;
    wps_pkg::result_t  out_data_reg;
    wps_pkg::result_t  result_next;

    logic        advance;
    logic        in_data;
    logic [6:0]  period;
    logic [15:0] frame_len;
    logic        load_slot;
    logic [23:0] shift_now;
    logic        cur_bit;
    logic [6:0]  high_ticks;
    logic [15:0] level;
    logic [6:0]  tick_plus;
    logic [BitW:0] bit_plus;
    logic [16:0] slot_plus;
    logic [10:0] pix_idx;
    logic [BitW-1:0] bit_tmp;

    assign advance   = item_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !item_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'd0, out_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_mask_reg   <= wps_pkg::LANE_MASK_RESET;
            pixel_count_reg <= wps_pkg::PIXEL_COUNT_RESET;
            bit_period_reg  <= wps_pkg::BIT_PERIOD_RESET;
            zero_high_reg   <= wps_pkg::ZERO_HIGH_RESET;
            one_high_reg    <= wps_pkg::ONE_HIGH_RESET;
            frame_slots_reg <= wps_pkg::FRAME_SLOTS_RESET;
            brightness_reg  <= wps_pkg::BRIGHTNESS_RESET;
            active_reg      <= 16'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                wps_pkg::REG_LANE_MASK: begin
                    lane_mask_reg <= cfg_data;
                end
                wps_pkg::REG_PIXEL_COUNT: begin
                    pixel_count_reg <= cfg_data[10:0];
                    active_reg      <= 16'(32'(cfg_data[10:0]) * BITS_PER_PIXEL);
                end
                wps_pkg::REG_BIT_PERIOD: begin
                    bit_period_reg <= cfg_data[6:0];
                end
                wps_pkg::REG_ZERO_HIGH: begin
                    zero_high_reg <= cfg_data[6:0];
                end
                wps_pkg::REG_ONE_HIGH: begin
                    one_high_reg <= cfg_data[6:0];
                end
                wps_pkg::REG_FRAME_SLOTS: begin
                    frame_slots_reg <= cfg_data;
                end
                wps_pkg::REG_BRIGHTNESS_SHIFT: begin
                    brightness_reg <= cfg_data[2:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            item_valid_reg <= 1'b1;
        end else if (advance) begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_op_reg    <= s_tuser[0];
            item_red_reg   <= s_tdata[7:0];
            item_green_reg <= s_tdata[15:8];
            item_blue_reg  <= s_tdata[23:16];
        end
    end

    always_comb begin
        hold_pixel_next    = hold_pixel_reg;
        hold_valid_next    = hold_valid_reg;
        shift_pixel_next   = shift_pixel_reg;
        bit_index_next     = bit_index_reg;
        tick_in_slot_next  = tick_in_slot_reg;
        slot_in_frame_next = slot_in_frame_reg;
        pixel_index_next   = pixel_index_reg;
        last_level_next    = last_level_reg;
        result_next        = '0;

        in_data    = slot_in_frame_reg < active_reg;
        period     = (bit_period_reg == 7'd0) ? 7'd1 : bit_period_reg;
        frame_len  = (frame_slots_reg > active_reg) ? frame_slots_reg : active_reg;
        if (frame_len == 16'd0) begin
            frame_len = 16'd1;
        end
        load_slot  = in_data && (tick_in_slot_reg == 7'd0) && (bit_index_reg == '0);
        shift_now  = (load_slot && hold_valid_reg) ? hold_pixel_reg : shift_pixel_reg;
        if (32'(bit_index_reg) < wps_pkg::COLOUR_BITS) begin
            cur_bit = shift_now[5'(wps_pkg::COLOUR_BITS - 1 - 32'(bit_index_reg))];
        end else begin
            cur_bit = 1'b0;
        end
        high_ticks = cur_bit ? one_high_reg : zero_high_reg;
        level      = (in_data && (tick_in_slot_reg < high_ticks))
                     ? (lane_mask_reg & LanePins) : 16'd0;
        tick_plus  = tick_in_slot_reg + 7'd1;
        bit_plus   = {1'b0, bit_index_reg} + {{BitW{1'b0}}, 1'b1};
        slot_plus  = {1'b0, slot_in_frame_reg} + 17'd1;
        pix_idx    = pixel_index_reg;
        bit_tmp    = bit_index_reg;

        if (item_op_reg == wps_pkg::OP_PIXEL) begin
            if (!hold_valid_reg) begin
                hold_pixel_next = {item_green_reg >> brightness_reg,
                                   item_red_reg >> brightness_reg,
                                   item_blue_reg >> brightness_reg};
                hold_valid_next = 1'b1;
                result_next.pixel_accepted = 1'b1;
            end
            result_next.pin_levels = last_level_reg;
            result_next.in_latch   = !in_data;
        end else begin
            if (load_slot) begin
                if (hold_valid_reg) begin
                    shift_pixel_next = hold_pixel_reg;
                    hold_valid_next  = 1'b0;
                end else begin
                    result_next.underrun = 1'b1;
                end
                pix_idx = pixel_index_reg + 11'd1;
            end
            last_level_next        = level;
            result_next.pin_levels = level;
            result_next.in_latch   = !in_data;

            if ((tick_plus >= period) || (tick_plus == 7'd0)) begin
                tick_in_slot_next = 7'd0;
                if (in_data) begin
                    bit_tmp = (32'(bit_plus) >= BITS_PER_PIXEL) ? '0 : bit_plus[BitW-1:0];
                end
                if (slot_plus >= {1'b0, frame_len}) begin
                    slot_in_frame_next = 16'd0;
                    bit_tmp            = '0;
                    pix_idx            = 11'd0;
                end else begin
                    slot_in_frame_next = slot_plus[15:0];
                end
            end else begin
                tick_in_slot_next = tick_plus;
            end
            bit_index_next   = bit_tmp;
            pixel_index_next = pix_idx;
        end
        result_next.wants_pixel = !hold_valid_next && (pixel_index_next < pixel_count_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_pixel_reg    <= 24'd0;
            hold_valid_reg    <= 1'b0;
            shift_pixel_reg   <= 24'd0;
            bit_index_reg     <= '0;
            tick_in_slot_reg  <= 7'd0;
            slot_in_frame_reg <= 16'd0;
            pixel_index_reg   <= 11'd0;
            last_level_reg    <= 16'd0;
        end else if (advance) begin
            hold_pixel_reg    <= hold_pixel_next;
            hold_valid_reg    <= hold_valid_next;
            shift_pixel_reg   <= shift_pixel_next;
            bit_index_reg     <= bit_index_next;
            tick_in_slot_reg  <= tick_in_slot_next;
            slot_in_frame_reg <= slot_in_frame_next;
            pixel_index_reg   <= pixel_index_next;
            last_level_reg    <= last_level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result_next;
        end
    end

    // a result never reports both a taken pixel and a starved slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_data_reg.underrun && out_data_reg.pixel_accepted))
        else $error("underrun and pixel taken in one result");

    // the hold register only empties on a tick that loads the shifter
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(hold_valid_reg) |->
            (!$past(aresetn) || ($past(advance) && ($past(item_op_reg) == wps_pkg::OP_TICK))))
        else $error("hold register emptied without a tick");

    // bit position stays inside a pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(bit_index_reg) < BITS_PER_PIXEL)
        else $error("bit index beyond pixel width");

    // a starved slot is flagged only on a tick at the start of a pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && result_next.underrun) |->
            (!hold_valid_reg && (tick_in_slot_reg == 7'd0) && (bit_index_reg == '0)))
        else $error("underrun outside a pixel start");

endmodule

// ===== verif/ws2812_pixel_serializer_unit_test.sv =====
// testbench of the led pixel serialiser: predicted pin levels and status flags checked per result transaction
module ws2812_pixel_serializer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RESULT_LATENCY = 2;
    localparam int unsigned CYCLE_LIMIT    = 60000;
    localparam int unsigned COLOUR_TOP     = wps_pkg::COLOUR_BITS - 1;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [23:0]                     s_tdata;
    logic [0:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [23:0]                     m_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    wps_pkg::cfg_index_t             cfg_index;
    logic [wps_pkg::CFG_DATA_W-1:0]  cfg_data;

    // register copies
    logic [15:0] lane_mask_q;
    logic [10:0] pixel_count_q;
    logic [6:0]  bit_period_q;
    logic [6:0]  zero_high_q;
    logic [6:0]  one_high_q;
    logic [15:0] frame_slots_q;
    logic [2:0]  brightness_q;

    // serialiser state copies
    logic [23:0] hold_pixel;
    logic        hold_valid;
    logic [23:0] shift_pixel;
    logic [4:0]  bit_idx;
    logic [6:0]  tick_in_slot;
    logic [15:0] slot_in_frame;
    logic [10:0] pixel_idx;
    logic [15:0] last_level;

    wps_pkg::result_t pin_results_due[$];
    int unsigned      fail_count;
    int unsigned      cycle_count;
    int unsigned      receiver_hold;
    bit               sender_gaps;
    bit               receiver_stalls;

    ws2812_pixel_serializer_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic wps_pkg::result_t advance_serializer(input logic op,
                                                            input logic [7:0] red,
                                                            input logic [7:0] green,
                                                            input logic [7:0] blue);
        wps_pkg::result_t res;
        int unsigned      active;
        int unsigned      period;
        int unsigned      frame_len;
        int unsigned      high_ticks;
        int unsigned      next_slot;
        logic             in_data;
        logic             cur_bit;
        logic [15:0]      level;
        res       = '0;
        active    = int'(pixel_count_q) * wps_pkg::BPP_DEFAULT;
        in_data   = int'(slot_in_frame) < active;
        if (op == wps_pkg::OP_PIXEL) begin
            if (!hold_valid) begin
                hold_pixel         = {green >> brightness_q, red >> brightness_q,
                                      blue >> brightness_q};
                hold_valid         = 1'b1;
                res.pixel_accepted = 1'b1;
            end
            level = last_level;
        end else begin
            period    = (bit_period_q < 7'd1) ? 1 : int'(bit_period_q);
            frame_len = (int'(frame_slots_q) > active) ? int'(frame_slots_q) : active;
            if (frame_len < 1) begin
                frame_len = 1;
            end
            if (in_data && tick_in_slot == 7'd0 && bit_idx == 5'd0) begin
                if (hold_valid) begin
                    shift_pixel = hold_pixel;
                    hold_valid  = 1'b0;
                end else begin
                    res.underrun = 1'b1;
                end
                pixel_idx = pixel_idx + 11'd1;
            end
            level = '0;
            if (in_data) begin
                cur_bit    = (bit_idx < wps_pkg::COLOUR_BITS)
                             ? shift_pixel[COLOUR_TOP - bit_idx] : 1'b0;
                high_ticks = cur_bit ? int'(one_high_q) : int'(zero_high_q);
                if (int'(tick_in_slot) < high_ticks) begin
                    level = lane_mask_q;
                end
            end
            last_level   = level;
            tick_in_slot = tick_in_slot + 7'd1;
            if (int'(tick_in_slot) >= period || tick_in_slot == 7'd0) begin
                tick_in_slot = '0;
                if (in_data) begin
                    bit_idx = bit_idx + 5'd1;
                    if (bit_idx >= wps_pkg::BPP_DEFAULT) begin
                        bit_idx = '0;
                    end
                end
                next_slot = int'(slot_in_frame) + 1;
                if (next_slot >= frame_len) begin
                    slot_in_frame = '0;
                    bit_idx       = '0;
                    pixel_idx     = '0;
                end else begin
                    slot_in_frame = next_slot[15:0];
                end
            end
        end
        res.pin_levels  = level;
        res.in_latch    = !in_data;
        res.wants_pixel = !hold_valid && (pixel_idx < pixel_count_q);
        return res;
    endfunction

    task automatic write_reg(input wps_pkg::cfg_index_t idx,
                             input logic [wps_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            wps_pkg::REG_LANE_MASK:        lane_mask_q   = value[15:0];
            wps_pkg::REG_PIXEL_COUNT:      pixel_count_q = value[10:0];
            wps_pkg::REG_BIT_PERIOD:       bit_period_q  = value[6:0];
            wps_pkg::REG_ZERO_HIGH:        zero_high_q   = value[6:0];
            wps_pkg::REG_ONE_HIGH:         one_high_q    = value[6:0];
            wps_pkg::REG_FRAME_SLOTS:      frame_slots_q = value[15:0];
            wps_pkg::REG_BRIGHTNESS_SHIFT: brightness_q  = value[2:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] lanes, input logic [10:0] pixels,
                                  input logic [6:0] period, input logic [6:0] zero_ticks,
                                  input logic [6:0] one_ticks, input logic [15:0] slots,
                                  input logic [2:0] shift);
        write_reg(wps_pkg::REG_LANE_MASK, lanes);
        write_reg(wps_pkg::REG_PIXEL_COUNT, 16'(pixels));
        write_reg(wps_pkg::REG_BIT_PERIOD, 16'(period));
        write_reg(wps_pkg::REG_ZERO_HIGH, 16'(zero_ticks));
        write_reg(wps_pkg::REG_ONE_HIGH, 16'(one_ticks));
        write_reg(wps_pkg::REG_FRAME_SLOTS, slots);
        write_reg(wps_pkg::REG_BRIGHTNESS_SHIFT, 16'(shift));
    endtask

    task automatic drive_item(input logic op, input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
        int unsigned gap;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {blue, green, red};
        do @(posedge aclk); while (!s_tready);
        pin_results_due.push_back(advance_serializer(op, red, green, blue));
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pin_results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (RESULT_LATENCY + 2) @(posedge aclk);
    endtask

    // offers a pixel with feed_pct percent chance while one is wanted, else mostly ticks
    task automatic run_traffic(input int unsigned count, input int unsigned feed_pct);
        logic op;
        for (int unsigned i = 0; i < count; i++) begin
            if (!hold_valid && pixel_idx < pixel_count_q) begin
                op = ($urandom_range(1, 100) <= feed_pct) ? wps_pkg::OP_PIXEL : wps_pkg::OP_TICK;
            end else begin
                op = ($urandom_range(0, 9) == 0) ? wps_pkg::OP_PIXEL : wps_pkg::OP_TICK;
            end
            drive_item(op, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_reset_state();
        drive_item(wps_pkg::OP_TICK, 8'h00, 8'h00, 8'h00);
        drive_item(wps_pkg::OP_PIXEL, 8'hff, 8'hff, 8'hff);
        drive_item(wps_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
        drive_item(wps_pkg::OP_TICK, 8'h00, 8'h00, 8'h00);
        drive_item(wps_pkg::OP_TICK, 8'hff, 8'hff, 8'hff);
        settle();
    endtask

    task automatic test_directed_frame();
        // short frame, one high time beyond the slot
        apply_settings(16'hffff, 11'd1, 7'd2, 7'd1, 7'd127, 16'd1, 3'd0);
        drive_item(wps_pkg::OP_TICK, 8'h00, 8'h00, 8'h00);
        drive_item(wps_pkg::OP_PIXEL, 8'hff, 8'h00, 8'hff);
        drive_item(wps_pkg::OP_PIXEL, 8'h00, 8'hff, 8'h00);
        repeat (6) drive_item(wps_pkg::OP_TICK, 8'h00, 8'h00, 8'h00);
        drive_item(wps_pkg::OP_PIXEL, 8'h80, 8'h01, 8'h7f);
        repeat (6) drive_item(wps_pkg::OP_TICK, 8'hff, 8'hff, 8'hff);
        settle();
        write_reg(wps_pkg::REG_BRIGHTNESS_SHIFT, 16'd7);
        repeat (4) drive_item(wps_pkg::OP_TICK, 8'h00, 8'h00, 8'h00);
        drive_item(wps_pkg::OP_PIXEL, 8'hff, 8'hff, 8'hff);
        settle();
    endtask

    task automatic test_random_settings(input int unsigned phases);
        logic [6:0] period;
        for (int unsigned p = 0; p < phases; p++) begin
            period = 7'($urandom_range(2, 5));
            apply_settings(16'($urandom), 11'($urandom_range(0, 3)), period,
                           7'($urandom_range(1, period + 1)), 7'($urandom_range(1, period + 1)),
                           16'($urandom_range(1, 120)), 3'($urandom_range(0, 7)));
            run_traffic(50, $urandom_range(2, 40));
            settle();
        end
    endtask

    task automatic test_extreme_settings();
        apply_settings(16'h0000, 11'd2047, 7'd127, 7'd127, 7'd1, 16'd65535, 3'd7);
        run_traffic(30, 50);
        settle();
    endtask

    task automatic test_backpressure();
        apply_settings(16'ha5c3, 11'd2, 7'd2, 7'd1, 7'd2, 16'd60, 3'd1);
        sender_gaps   = 1'b0;
        receiver_hold = 80;
        run_traffic(30, 30);
        sender_gaps = 1'b1;
        settle();
    endtask

    task automatic test_sender_pause();
        run_traffic(15, 30);
        settle();
        run_traffic(15, 10);
        settle();
    endtask

    task automatic test_steady_stream();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        apply_settings(16'h5a3c, 11'd3, 7'd3, 7'd1, 7'd2, 16'd80, 3'd2);
        run_traffic(60, 25);
        settle();
    endtask

    // result side ready pattern
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (receiver_hold > 0) begin
                m_tready      = 1'b0;
                receiver_hold = receiver_hold - 1;
            end else if (stall_left > 0) begin
                m_tready   = 1'b0;
                stall_left = stall_left - 1;
            end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(0, 7);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        wps_pkg::result_t got;
        wps_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = wps_pkg::result_t'(m_tdata[19:0]);
            if (pin_results_due.size() == 0) begin
                $error("unexpected result transaction: %h", m_tdata);
                fail_count++;
            end else begin
                want = pin_results_due.pop_front();
                if (got.pin_levels !== want.pin_levels) begin
                    $error("pin_levels: expected %h, got %h", want.pin_levels, got.pin_levels);
                    fail_count++;
                end
                if (got.pixel_accepted !== want.pixel_accepted) begin
                    $error("pixel_accepted: expected %b, got %b", want.pixel_accepted,
                           got.pixel_accepted);
                    fail_count++;
                end
                if (got.wants_pixel !== want.wants_pixel) begin
                    $error("wants_pixel: expected %b, got %b", want.wants_pixel,
                           got.wants_pixel);
                    fail_count++;
                end
                if (got.in_latch !== want.in_latch) begin
                    $error("in_latch: expected %b, got %b", want.in_latch, got.in_latch);
                    fail_count++;
                end
                if (got.underrun !== want.underrun) begin
                    $error("underrun: expected %b, got %b", want.underrun, got.underrun);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = wps_pkg::OP_TICK;
        cfg_valid       = 1'b0;
        cfg_index       = wps_pkg::REG_LANE_MASK;
        cfg_data        = '0;
        fail_count      = 0;
        receiver_hold   = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        lane_mask_q     = wps_pkg::LANE_MASK_RESET;
        pixel_count_q   = wps_pkg::PIXEL_COUNT_RESET;
        bit_period_q    = wps_pkg::BIT_PERIOD_RESET;
        zero_high_q     = wps_pkg::ZERO_HIGH_RESET;
        one_high_q      = wps_pkg::ONE_HIGH_RESET;
        frame_slots_q   = wps_pkg::FRAME_SLOTS_RESET;
        brightness_q    = wps_pkg::BRIGHTNESS_RESET;
        hold_pixel      = '0;
        hold_valid      = 1'b0;
        shift_pixel     = '0;
        bit_idx         = '0;
        tick_in_slot    = '0;
        slot_in_frame   = '0;
        pixel_idx       = '0;
        last_level      = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_state();
        test_directed_frame();
        test_random_settings(4);
        test_extreme_settings();
        test_random_settings(1);
        test_backpressure();
        test_sender_pause();
        test_steady_stream();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/wps_pkg.sv
src/ws2812_pixel_serializer_unit.sv
verif/ws2812_pixel_serializer_unit_test.sv
